FILE: sv/bced_pkg.sv
// ----------------------------------------------------------------------------
// bced_pkg
// Types and constants shared by the button click event detector.
// ----------------------------------------------------------------------------
package bced_pkg;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		EV_PRESSED  = 2'd0,
		EV_RELEASED = 2'd1,
		EV_DOUBLE   = 2'd2,
		EV_LONG     = 2'd3
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_DOUBLE   = 2'd1,
		CFG_LONG     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] double_click_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	// Classification of the item held in the input register.
	typedef struct packed {
		logic              fire;
		logic              emit;
		event_kind_t       kind;
		logic [TIME_W-1:0] event_time;
		logic              is_pressed;
	} cls_res_t;

endpackage

FILE: sv/bced_item_if.sv
// ----------------------------------------------------------------------------
// bced_item_if
// Input channel: a button edge or a poll, with the current time.
// ----------------------------------------------------------------------------
interface bced_item_if;
	logic                        valid;
	logic                        ready;
	bced_pkg::op_t               op;
	logic [bced_pkg::TIME_W-1:0] time_ms;

	modport source (output valid, output op, output time_ms, input ready);
	modport sink   (input valid, input op, input time_ms, output ready);
endinterface

FILE: sv/bced_event_if.sv
// ----------------------------------------------------------------------------
// bced_event_if
// Output channel: one classified button event.
// ----------------------------------------------------------------------------
interface bced_event_if;
	logic                        valid;
	logic                        ready;
	bced_pkg::event_kind_t       event_kind;
	logic [bced_pkg::TIME_W-1:0] event_time;
	logic                        is_pressed;

	modport source (output valid, output event_kind, output event_time,
		output is_pressed, input ready);
	modport sink   (input valid, input event_kind, input event_time,
		input is_pressed, output ready);
endinterface

FILE: sv/bced_cfg_if.sv
// ----------------------------------------------------------------------------
// bced_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bced_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bced_pkg::CFG_IDX_W-1:0] index;
	logic [bced_pkg::CFG_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/button_click_event_detector.sv
// ----------------------------------------------------------------------------
// button_click_event_detector
// Debounces button edges and reports press, release, double click and long
// press events.
// ----------------------------------------------------------------------------
// Channel  Role   Transaction
// item     sink   one button edge or poll with the current time in ms
// result   source one event: kind, time and pressed flag after the item
// cfg      sink   one write of a time register (debounce, double, long)
//
// One item is taken every cycle while result is not stalled; an event passes
// through the input register, then the result register.
// Edges inside the debounce window and polls with nothing to report produce
// no transaction on result.
// Reset clears the button state and loads the default time registers.
// A stalled result holds the result register, and the input register drains
// into it once the result transaction completes.
// ----------------------------------------------------------------------------
module button_click_event_detector (
	input  logic          clk,
	input  logic          arst_n,
	bced_item_if.sink     item,
	bced_event_if.source  result,
	bced_cfg_if.sink      cfg
);

	bced_pkg::cfg_t              cfg_val;
	bced_pkg::cls_res_t          res;
	logic                        out_free;
	logic                        load;
	logic                        valid_s2;
	bced_pkg::event_kind_t       kind_s2;
	logic [bced_pkg::TIME_W-1:0] time_s2;
	logic                        pressed_s2;

	bced_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	bced_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_val  (cfg_val),
		.out_free (out_free),
		.res      (res)
	);

	assign out_free = !valid_s2 || result.ready;
	assign load     = res.fire && res.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s2    <= res.kind;
			time_s2    <= res.event_time;
			pressed_s2 <= res.is_pressed;
		end
	end

	assign result.valid      = valid_s2;
	assign result.event_kind = kind_s2;
	assign result.event_time = time_s2;
	assign result.is_pressed = pressed_s2;

endmodule

FILE: sv/bced_cfg_regs.sv
// ----------------------------------------------------------------------------
// bced_cfg_regs
// Debounce, double click and long press time registers.
// ----------------------------------------------------------------------------
module bced_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	bced_cfg_if.sink        cfg,
	output bced_pkg::cfg_t  cfg_val
);

	bced_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bced_pkg::DEBOUNCE_RST;
			cfg_q.double_click_ms <= bced_pkg::DOUBLE_RST;
			cfg_q.long_press_ms   <= bced_pkg::LONG_RST;
		end else if (cfg.valid) begin
			// Writes to an index beyond the register list are dropped.
			case (cfg.index)
				bced_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms     <= cfg.wdata;
				bced_pkg::CFG_DOUBLE:   cfg_q.double_click_ms <= cfg.wdata;
				bced_pkg::CFG_LONG:     cfg_q.long_press_ms   <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/bced_core.sv
// ----------------------------------------------------------------------------
// bced_core
// Input register, button state and combinational event classification.
// ----------------------------------------------------------------------------
module bced_core (
	input  logic               clk,
	input  logic               arst_n,
	bced_item_if.sink          item,
	input  bced_pkg::cfg_t     cfg_val,
	input  logic               out_free,
	output bced_pkg::cls_res_t res
);

	logic                        valid_s1;
	bced_pkg::op_t               op_s1;
	logic [bced_pkg::TIME_W-1:0] time_s1;

	logic                        pressed_q;
	logic [bced_pkg::TIME_W-1:0] press_start_q;
	logic [bced_pkg::TIME_W-1:0] last_click_q;
	logic [bced_pkg::TIME_W-1:0] last_edge_q;

	logic                        accept;
	logic                        retire;
	logic [bced_pkg::TIME_W-1:0] since_edge;
	logic [bced_pkg::TIME_W-1:0] since_click;
	logic [bced_pkg::TIME_W-1:0] since_press;
	logic                        edge_take;
	logic                        dbl_hit;
	logic                        long_hit;

	assign retire     = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= item.op;
			time_s1 <= item.time_ms;
		end
	end

	// All time differences wrap modulo the timestamp width.
	assign since_edge  = time_s1 - last_edge_q;
	assign since_click = time_s1 - last_click_q;
	assign since_press = time_s1 - press_start_q;

	assign edge_take = (op_s1 == bced_pkg::OP_EDGE) &&
		(since_edge >= {{(bced_pkg::TIME_W-bced_pkg::CFG_W){1'b0}}, cfg_val.debounce_ms});
	assign dbl_hit = since_click <
		{{(bced_pkg::TIME_W-bced_pkg::CFG_W){1'b0}}, cfg_val.double_click_ms};
	assign long_hit = (op_s1 == bced_pkg::OP_POLL) && pressed_q &&
		(press_start_q != '0) &&
		(since_press >= {{(bced_pkg::TIME_W-bced_pkg::CFG_W){1'b0}}, cfg_val.long_press_ms});

	always_comb begin
		res.fire       = retire;
		res.emit       = edge_take || long_hit;
		res.event_time = time_s1;
		res.is_pressed = edge_take ? !pressed_q : pressed_q;
		if (!edge_take) begin
			res.kind = bced_pkg::EV_LONG;
		end else if (pressed_q) begin
			res.kind = bced_pkg::EV_RELEASED;
		end else if (dbl_hit) begin
			res.kind = bced_pkg::EV_DOUBLE;
		end else begin
			res.kind = bced_pkg::EV_PRESSED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= 1'b0;
			press_start_q <= '0;
			last_click_q  <= '0;
			last_edge_q   <= '0;
		end else if (retire) begin
			if (edge_take) begin
				last_edge_q <= time_s1;
				pressed_q   <= !pressed_q;
				if (pressed_q) begin
					press_start_q <= '0;
				end else begin
					press_start_q <= time_s1;
					// A double click consumes the recorded click.
					last_click_q  <= dbl_hit ? '0 : time_s1;
				end
			end else if (long_hit) begin
				press_start_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_long_clears_start: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && long_hit) |=> (press_start_q == '0))
		else $error("press start not cleared after a long press");

	a_flag_only_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!(retire && edge_take) |=> $stable(pressed_q))
		else $error("pressed flag changed without an accepted edge");

	a_long_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && long_hit) |-> (pressed_q && !edge_take))
		else $error("long press while released or on an edge");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && edge_take && pressed_q) |=> (!pressed_q && press_start_q == '0))
		else $error("release left the button pressed");
`endif

endmodule
